// ----- rtl/hps_pkg.sv -----
package hps_pkg;

	localparam logic [7:0]  COUNT_AT_RESET = 8'd120;
	localparam logic [63:0] SEED_AT_RESET  = 64'h243f6a8885a308d3;

	localparam logic [1:0] CFG_VERTEX_COUNT = 2'd0;
	localparam logic [1:0] CFG_START_VERTEX = 2'd1;
	localparam logic [1:0] CFG_RNG_SEED     = 2'd2;

	localparam logic [2:0] STS_ACK    = 3'd0;
	localparam logic [2:0] STS_EXT    = 3'd1;
	localparam logic [2:0] STS_DEAD   = 3'd2;
	localparam logic [2:0] STS_CLOSED = 3'd3;
	localparam logic [2:0] STS_OPEN   = 3'd4;
	localparam logic [2:0] STS_IGN    = 3'd5;

	typedef enum logic [1:0] {
		CMD_ADD   = 2'd0,
		CMD_START = 2'd1,
		CMD_STEP  = 2'd2,
		CMD_CLEAR = 2'd3
	} cmd_t;

	typedef struct packed {
		logic [1:0] command;
		logic [6:0] vertex;
		logic [6:0] neighbor;
	} item_t;

	typedef struct packed {
		logic [2:0] status;
		logic [2:0] branching;
		logic [6:0] chosen_vertex;
		logic [7:0] path_depth;
	} result_t;

	typedef enum logic [4:0] {
		S_IDLE, S_DEC, S_IGN, S_CLR, S_ADD_RD, S_ADD_WR, S_START,
		S_VI_ROW, S_VI_DEG, S_VI_NL, S_VI_CNT, S_VI_WR, S_START_FIN, S_STEP_FIN,
		S_SROW_RD, S_SROW_CAP, S_SC_RD, S_SC_EV, S_HD_RD, S_HD_CAP,
		S_CH_NL, S_CH_CHK, S_FL_FIND, S_FL_MRG, S_FL_END, S_CH_END,
		S_DIV_GO, S_DIV_WAIT, S_PICK, S_DONE
	} state_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_CAPTURE, OP_IGNORE, OP_CLEAR, OP_ADD_RD, OP_ADD_WR, OP_START,
		OP_VI_ROW, OP_VI_DEG, OP_VI_NL, OP_VI_CNT, OP_VI_WR, OP_START_FIN,
		OP_STEP_FIN, OP_SROW_RD, OP_SROW_CAP, OP_SC_RD, OP_SC_EV, OP_HD_RD,
		OP_HD_CAP, OP_CH_NL, OP_CH_CHK, OP_FL_FIND, OP_FL_MRG, OP_FL_END,
		OP_CH_END, OP_DIV_GO, OP_PICK
	} dp_op_t;

	typedef struct packed {
		cmd_t cmd;
		logic active;
		logic add_ok;
		logic start_ok;
		logic vi_more;
		logic scan_last;
		logic ch_more;
		logic w_ok;
		logic fl_empty;
		logic no_child;
		logic rem_done;
	} dp_stat_t;

endpackage

// ----- rtl/hps_rem.sv -----
module hps_rem #(
	parameter int DW = 3
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          go,
	input  logic [63:0]   dividend,
	input  logic [DW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] rem
);

	logic [63:0]   sh_q;
	logic [DW-1:0] rem_q;
	logic [5:0]    cnt_q;
	logic          run_q;
	logic          done_q;
	logic [DW:0]   trial;
	logic [DW:0]   diff;
	logic [DW-1:0] rem_next;

	// restoring remainder, one dividend bit per cycle
	always_comb begin
		trial = {rem_q, sh_q[63]};
		diff = trial - {1'b0, divisor};
		rem_next = (trial >= {1'b0, divisor}) ? diff[DW-1:0] : trial[DW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sh_q <= '0;
			rem_q <= '0;
			cnt_q <= '0;
			run_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				sh_q <= dividend;
				rem_q <= '0;
				cnt_q <= '0;
				run_q <= 1'b1;
			end else if (run_q) begin
				sh_q <= {sh_q[62:0], 1'b0};
				rem_q <= rem_next;
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign rem = rem_q;

endmodule

// ----- rtl/hps_dp.sv -----
module hps_dp #(
	parameter int MAX_VERTICES = 128,
	parameter int MAX_DEGREE = 6
) (
	input  logic             clk,
	input  logic             arst_n,
	input  hps_pkg::dp_op_t  op,
	input  hps_pkg::item_t   request,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [63:0]      cfg_data,
	output hps_pkg::dp_stat_t stat,
	output hps_pkg::result_t result
);

	localparam int MAXV = MAX_VERTICES;
	localparam int VW = $clog2(MAXV);
	localparam int DW = $clog2(MAX_DEGREE + 1);
	localparam int KW = $clog2(MAX_DEGREE);
	localparam int CW = VW + 1;
	localparam int FW = ((CW > DW) ? CW : DW) + 1;
	localparam int NL_DEPTH = MAXV * (2 ** KW);

	hps_pkg::item_t   req_q;
	hps_pkg::result_t result_q;

	logic [7:0]  vcount_q;
	logic [6:0]  svert_q;
	logic [63:0] rnd_q;
	logic [7:0]  n_eff;
	logic [VW-1:0] sv;

	// adjacency rows with degree, one valid bit per row
	logic [DW+MAXV-1:0] adj_mem [MAXV];
	logic [DW+MAXV-1:0] adj_rd_q;
	logic               adj_rv_q;
	logic [MAXV-1:0]    row_vld_q;
	logic [VW-1:0]      adj_addr;
	logic [DW+MAXV-1:0] adj_word;
	logic [MAXV-1:0]    adj_bits;
	logic [DW-1:0]      adj_deg;

	logic [VW-1:0]    nl_mem [NL_DEPTH];
	logic [VW-1:0]    nl_rd_q;
	logic [VW+KW-1:0] nl_addr;
	logic             nl_re;

	// visited-list hit counts; free degree is degree minus this count
	logic [CW-1:0]   cnt_mem [MAXV];
	logic [CW-1:0]   cnt_rd_q;
	logic            cnt_rv_q;
	logic [MAXV-1:0] cnt_vld_q;
	logic [VW-1:0]   cnt_addr;
	logic [CW-1:0]   cnt_word;

	logic [MAXV-1:0] visited_q;
	logic [VW-1:0]   head_q;
	logic [VW-1:0]   tgt_q;
	logic [7:0]      len_q;
	logic            active_q;
	logic [MAXV-1:0] srow_q;
	logic [VW-1:0]   u_q;
	logic signed [FW-1:0] fstart_q;
	logic [1:0]      fail_n_q;
	logic [VW-1:0]   fail_u_q;
	logic [DW-1:0]   hdeg_q;
	logic [DW-1:0]   tdeg_q;
	logic [DW-1:0]   k_q;
	logic [VW-1:0]   w_q;
	logic [MAXV-1:0] reach_q;
	logic [MAXV-1:0] proc_q;
	logic [VW-1:0]   fv_q;
	logic            adjws_q;
	logic            closed_q;
	logic [VW-1:0]   child_q [MAX_DEGREE];
	logic [DW-1:0]   c_q;

	logic [MAXV-1:0] cand;
	logic [VW-1:0]   fv_next;
	logic [MAXV-1:0] allowed;
	logic signed [FW-1:0] free_u;
	logic signed [FW:0]   sum_u;
	logic            fail_now;
	logic signed [FW-1:0] fs_adj;
	logic            gate;
	logic            degok;
	logic            conn;
	logic [VW-1:0]   vidx;
	logic [VW-1:0]   nidx;
	logic            add_new;
	logic [63:0]     x1, x2, x3;
	logic            div_done;
	logic [DW-1:0]   div_rem;
	logic [VW-1:0]   pick;

	assign n_eff = (vcount_q > 8'(MAXV)) ? 8'(MAXV) : vcount_q;
	assign sv = svert_q[VW-1:0];
	assign vidx = req_q.vertex[VW-1:0];
	assign nidx = req_q.neighbor[VW-1:0];

	assign adj_word = adj_rv_q ? adj_rd_q : '0;
	assign adj_bits = adj_word[MAXV-1:0];
	assign adj_deg = adj_word[DW+MAXV-1:MAXV];
	assign cnt_word = cnt_rv_q ? cnt_rd_q : '0;
	assign add_new = !adj_bits[nidx] && (adj_deg < DW'(MAX_DEGREE));

	always_comb begin
		cand = reach_q & ~proc_q;
		fv_next = '0;
		for (int i = MAXV - 1; i >= 0; i--) begin
			if (cand[i]) begin
				fv_next = VW'(i);
			end
		end
	end

	always_comb begin
		for (int i = 0; i < MAXV; i++) begin
			allowed[i] = (8'(i) < n_eff) && !visited_q[i];
		end
		allowed[sv] = 1'b1;
		allowed[w_q] = 1'b1;
	end

	always_comb begin
		free_u = $signed(FW'(adj_deg)) - $signed(FW'(cnt_word));
		sum_u = (FW+1)'(free_u) + $signed((FW+1)'(srow_q[u_q]));
		fail_now = (8'(u_q) < n_eff) && !visited_q[u_q] && (sum_u < $signed((FW+1)'(2)));
		fs_adj = fstart_q - $signed(FW'(adjws_q));
		gate = (fs_adj > $signed(FW'(0))) || ((len_q + 8'd1) == n_eff);
		degok = (fail_n_q == 2'd0) || ((fail_n_q == 2'd1) && (fail_u_q == w_q));
		conn = ((allowed & ~reach_q) == '0);
	end

	always_comb begin
		x1 = rnd_q ^ (rnd_q << 13);
		x2 = x1 ^ (x1 >> 7);
		x3 = x2 ^ (x2 << 17);
	end

	hps_rem #(.DW(DW)) u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (op == hps_pkg::OP_DIV_GO),
		.dividend (rnd_q),
		.divisor  (c_q),
		.done     (div_done),
		.rem      (div_rem)
	);

	assign pick = child_q[div_rem[KW-1:0]];

	always_comb begin
		case (op)
			hps_pkg::OP_ADD_RD:  adj_addr = vidx;
			hps_pkg::OP_VI_ROW:  adj_addr = tgt_q;
			hps_pkg::OP_SROW_RD: adj_addr = sv;
			hps_pkg::OP_SC_RD:   adj_addr = u_q;
			hps_pkg::OP_FL_FIND: adj_addr = fv_next;
			default:             adj_addr = head_q;
		endcase
		case (op)
			hps_pkg::OP_VI_CNT: cnt_addr = nl_rd_q;
			default:            cnt_addr = u_q;
		endcase
		case (op)
			hps_pkg::OP_VI_NL: nl_addr = {tgt_q, k_q[KW-1:0]};
			default:           nl_addr = {head_q, k_q[KW-1:0]};
		endcase
		nl_re = (op == hps_pkg::OP_VI_NL) || (op == hps_pkg::OP_CH_NL);
	end

	always_ff @(posedge clk) begin
		if (op == hps_pkg::OP_ADD_WR && add_new) begin
			adj_mem[vidx] <= {adj_deg + DW'(1), adj_bits | (MAXV'(1) << nidx)};
		end
		adj_rd_q <= adj_mem[adj_addr];
	end

	always_ff @(posedge clk) begin
		if (op == hps_pkg::OP_ADD_WR && add_new) begin
			nl_mem[{vidx, adj_deg[KW-1:0]}] <= nidx;
		end
		if (nl_re) begin
			nl_rd_q <= nl_mem[nl_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (op == hps_pkg::OP_VI_WR) begin
			cnt_mem[nl_rd_q] <= cnt_word + CW'(1);
		end
		cnt_rd_q <= cnt_mem[cnt_addr];
	end

	always_ff @(posedge clk) begin
		if (op == hps_pkg::OP_FL_END && gate && degok && conn) begin
			child_q[c_q[KW-1:0]] <= w_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_q <= '0;
			result_q <= '0;
			vcount_q <= hps_pkg::COUNT_AT_RESET;
			svert_q <= '0;
			rnd_q <= hps_pkg::SEED_AT_RESET;
			adj_rv_q <= 1'b0;
			row_vld_q <= '0;
			cnt_rv_q <= 1'b0;
			cnt_vld_q <= '0;
			visited_q <= '0;
			head_q <= '0;
			tgt_q <= '0;
			len_q <= '0;
			active_q <= 1'b0;
			srow_q <= '0;
			u_q <= '0;
			fstart_q <= '0;
			fail_n_q <= '0;
			fail_u_q <= '0;
			hdeg_q <= '0;
			tdeg_q <= '0;
			k_q <= '0;
			w_q <= '0;
			reach_q <= '0;
			proc_q <= '0;
			fv_q <= '0;
			adjws_q <= 1'b0;
			closed_q <= 1'b0;
			c_q <= '0;
		end else begin
			adj_rv_q <= row_vld_q[adj_addr];
			cnt_rv_q <= cnt_vld_q[cnt_addr];
			if (cfg_we) begin
				case (cfg_index)
					hps_pkg::CFG_VERTEX_COUNT: begin
						vcount_q <= cfg_data[7:0];
						active_q <= 1'b0;
					end
					hps_pkg::CFG_START_VERTEX: begin
						svert_q <= cfg_data[6:0];
						active_q <= 1'b0;
					end
					hps_pkg::CFG_RNG_SEED: begin
						rnd_q <= cfg_data;
					end
					default: begin
					end
				endcase
			end
			case (op)
				hps_pkg::OP_CAPTURE: begin
					req_q <= request;
				end
				hps_pkg::OP_IGNORE: begin
					result_q <= {hps_pkg::STS_IGN, 3'd0, 7'd0, len_q};
				end
				hps_pkg::OP_CLEAR: begin
					row_vld_q <= '0;
					result_q <= {hps_pkg::STS_ACK, 3'd0, 7'd0, len_q};
				end
				hps_pkg::OP_ADD_WR: begin
					if (add_new) begin
						row_vld_q[vidx] <= 1'b1;
						result_q <= {hps_pkg::STS_ACK, 3'd0, 7'd0, len_q};
					end else begin
						result_q <= {hps_pkg::STS_IGN, 3'd0, 7'd0, len_q};
					end
				end
				hps_pkg::OP_START: begin
					visited_q <= MAXV'(1) << sv;
					cnt_vld_q <= '0;
					head_q <= sv;
					tgt_q <= sv;
					len_q <= 8'd1;
					active_q <= 1'b1;
				end
				hps_pkg::OP_VI_DEG: begin
					tdeg_q <= adj_deg;
					closed_q <= adj_bits[sv];
					k_q <= '0;
				end
				hps_pkg::OP_VI_WR: begin
					cnt_vld_q[nl_rd_q] <= 1'b1;
					k_q <= k_q + DW'(1);
				end
				hps_pkg::OP_START_FIN: begin
					result_q <= {hps_pkg::STS_ACK, 3'd0, 7'(head_q), len_q};
				end
				hps_pkg::OP_SROW_CAP: begin
					srow_q <= adj_bits;
					u_q <= '0;
					fail_n_q <= '0;
				end
				hps_pkg::OP_SC_EV: begin
					if (fail_now) begin
						if (fail_n_q != 2'd2) begin
							fail_n_q <= fail_n_q + 2'd1;
						end
						fail_u_q <= u_q;
					end
					if (u_q == sv) begin
						fstart_q <= free_u;
					end
					u_q <= u_q + VW'(1);
				end
				hps_pkg::OP_HD_CAP: begin
					hdeg_q <= adj_deg;
					k_q <= '0;
					c_q <= '0;
				end
				hps_pkg::OP_CH_CHK: begin
					if (stat.w_ok) begin
						w_q <= nl_rd_q;
						reach_q <= MAXV'(1) << nl_rd_q;
						proc_q <= '0;
					end else begin
						k_q <= k_q + DW'(1);
					end
				end
				hps_pkg::OP_FL_FIND: begin
					if (cand != '0) begin
						proc_q[fv_next] <= 1'b1;
						fv_q <= fv_next;
					end
				end
				hps_pkg::OP_FL_MRG: begin
					reach_q <= reach_q | (adj_bits & allowed);
					if (fv_q == w_q) begin
						adjws_q <= adj_bits[sv];
					end
				end
				hps_pkg::OP_FL_END: begin
					if (gate && degok && conn) begin
						c_q <= c_q + DW'(1);
					end
					k_q <= k_q + DW'(1);
				end
				hps_pkg::OP_CH_END: begin
					if (c_q == '0) begin
						result_q <= {hps_pkg::STS_DEAD, 3'(c_q), 7'd0, len_q};
						active_q <= 1'b0;
					end else begin
						rnd_q <= x3;
					end
				end
				hps_pkg::OP_PICK: begin
					visited_q[pick] <= 1'b1;
					head_q <= pick;
					tgt_q <= pick;
					len_q <= len_q + 8'd1;
				end
				hps_pkg::OP_STEP_FIN: begin
					if (len_q >= n_eff) begin
						active_q <= 1'b0;
						result_q <= {closed_q ? hps_pkg::STS_CLOSED : hps_pkg::STS_OPEN,
							3'(c_q), 7'(head_q), len_q};
					end else begin
						result_q <= {hps_pkg::STS_EXT, 3'(c_q), 7'(head_q), len_q};
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		stat.cmd = hps_pkg::cmd_t'(req_q.command);
		stat.active = active_q;
		stat.add_ok = !active_q && (8'(req_q.vertex) < 8'(MAXV))
			&& (8'(req_q.neighbor) < 8'(MAXV)) && (req_q.vertex != req_q.neighbor);
		stat.start_ok = (n_eff >= 8'd2) && (8'(svert_q) < n_eff);
		stat.vi_more = k_q < tdeg_q;
		stat.scan_last = (u_q == VW'(MAXV - 1));
		stat.ch_more = k_q < hdeg_q;
		stat.w_ok = (8'(nl_rd_q) < n_eff) && !visited_q[nl_rd_q];
		stat.fl_empty = (cand == '0);
		stat.no_child = (c_q == '0);
		stat.rem_done = div_done;
	end

	assign result = result_q;

endmodule

// ----- rtl/hps_ctrl.sv -----
module hps_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  hps_pkg::dp_stat_t stat,
	output hps_pkg::dp_op_t   op,
	output logic              busy,
	output logic              done
);

	hps_pkg::state_t state_q, state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hps_pkg::S_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			hps_pkg::S_IDLE: if (start) state_next = hps_pkg::S_DEC;
			hps_pkg::S_DEC: begin
				case (stat.cmd)
					hps_pkg::CMD_ADD:
						state_next = stat.add_ok ? hps_pkg::S_ADD_RD : hps_pkg::S_IGN;
					hps_pkg::CMD_CLEAR:
						state_next = stat.active ? hps_pkg::S_IGN : hps_pkg::S_CLR;
					hps_pkg::CMD_START:
						state_next = stat.start_ok ? hps_pkg::S_START : hps_pkg::S_IGN;
					default:
						state_next = stat.active ? hps_pkg::S_SROW_RD : hps_pkg::S_IGN;
				endcase
			end
			hps_pkg::S_IGN:      state_next = hps_pkg::S_DONE;
			hps_pkg::S_CLR:      state_next = hps_pkg::S_DONE;
			hps_pkg::S_ADD_RD:   state_next = hps_pkg::S_ADD_WR;
			hps_pkg::S_ADD_WR:   state_next = hps_pkg::S_DONE;
			hps_pkg::S_START:    state_next = hps_pkg::S_VI_ROW;
			hps_pkg::S_VI_ROW:   state_next = hps_pkg::S_VI_DEG;
			hps_pkg::S_VI_DEG:   state_next = hps_pkg::S_VI_NL;
			hps_pkg::S_VI_NL: begin
				if (stat.vi_more) begin
					state_next = hps_pkg::S_VI_CNT;
				end else if (stat.cmd == hps_pkg::CMD_STEP) begin
					state_next = hps_pkg::S_STEP_FIN;
				end else begin
					state_next = hps_pkg::S_START_FIN;
				end
			end
			hps_pkg::S_VI_CNT:    state_next = hps_pkg::S_VI_WR;
			hps_pkg::S_VI_WR:     state_next = hps_pkg::S_VI_NL;
			hps_pkg::S_START_FIN: state_next = hps_pkg::S_DONE;
			hps_pkg::S_STEP_FIN:  state_next = hps_pkg::S_DONE;
			hps_pkg::S_SROW_RD:   state_next = hps_pkg::S_SROW_CAP;
			hps_pkg::S_SROW_CAP:  state_next = hps_pkg::S_SC_RD;
			hps_pkg::S_SC_RD:     state_next = hps_pkg::S_SC_EV;
			hps_pkg::S_SC_EV:
				state_next = stat.scan_last ? hps_pkg::S_HD_RD : hps_pkg::S_SC_RD;
			hps_pkg::S_HD_RD:     state_next = hps_pkg::S_HD_CAP;
			hps_pkg::S_HD_CAP:    state_next = hps_pkg::S_CH_NL;
			hps_pkg::S_CH_NL:
				state_next = stat.ch_more ? hps_pkg::S_CH_CHK : hps_pkg::S_CH_END;
			hps_pkg::S_CH_CHK:
				state_next = stat.w_ok ? hps_pkg::S_FL_FIND : hps_pkg::S_CH_NL;
			hps_pkg::S_FL_FIND:
				state_next = stat.fl_empty ? hps_pkg::S_FL_END : hps_pkg::S_FL_MRG;
			hps_pkg::S_FL_MRG:    state_next = hps_pkg::S_FL_FIND;
			hps_pkg::S_FL_END:    state_next = hps_pkg::S_CH_NL;
			hps_pkg::S_CH_END:
				state_next = stat.no_child ? hps_pkg::S_DONE : hps_pkg::S_DIV_GO;
			hps_pkg::S_DIV_GO:    state_next = hps_pkg::S_DIV_WAIT;
			hps_pkg::S_DIV_WAIT: if (stat.rem_done) state_next = hps_pkg::S_PICK;
			hps_pkg::S_PICK:      state_next = hps_pkg::S_VI_ROW;
			hps_pkg::S_DONE:      state_next = hps_pkg::S_IDLE;
			default:              state_next = hps_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		busy = (state_q != hps_pkg::S_IDLE);
		done = (state_q == hps_pkg::S_DONE);
		case (state_q)
			hps_pkg::S_IDLE:      op = start ? hps_pkg::OP_CAPTURE : hps_pkg::OP_NONE;
			hps_pkg::S_IGN:       op = hps_pkg::OP_IGNORE;
			hps_pkg::S_CLR:       op = hps_pkg::OP_CLEAR;
			hps_pkg::S_ADD_RD:    op = hps_pkg::OP_ADD_RD;
			hps_pkg::S_ADD_WR:    op = hps_pkg::OP_ADD_WR;
			hps_pkg::S_START:     op = hps_pkg::OP_START;
			hps_pkg::S_VI_ROW:    op = hps_pkg::OP_VI_ROW;
			hps_pkg::S_VI_DEG:    op = hps_pkg::OP_VI_DEG;
			hps_pkg::S_VI_NL:     op = hps_pkg::OP_VI_NL;
			hps_pkg::S_VI_CNT:    op = hps_pkg::OP_VI_CNT;
			hps_pkg::S_VI_WR:     op = hps_pkg::OP_VI_WR;
			hps_pkg::S_START_FIN: op = hps_pkg::OP_START_FIN;
			hps_pkg::S_STEP_FIN:  op = hps_pkg::OP_STEP_FIN;
			hps_pkg::S_SROW_RD:   op = hps_pkg::OP_SROW_RD;
			hps_pkg::S_SROW_CAP:  op = hps_pkg::OP_SROW_CAP;
			hps_pkg::S_SC_RD:     op = hps_pkg::OP_SC_RD;
			hps_pkg::S_SC_EV:     op = hps_pkg::OP_SC_EV;
			hps_pkg::S_HD_RD:     op = hps_pkg::OP_HD_RD;
			hps_pkg::S_HD_CAP:    op = hps_pkg::OP_HD_CAP;
			hps_pkg::S_CH_NL:     op = hps_pkg::OP_CH_NL;
			hps_pkg::S_CH_CHK:    op = hps_pkg::OP_CH_CHK;
			hps_pkg::S_FL_FIND:   op = hps_pkg::OP_FL_FIND;
			hps_pkg::S_FL_MRG:    op = hps_pkg::OP_FL_MRG;
			hps_pkg::S_FL_END:    op = hps_pkg::OP_FL_END;
			hps_pkg::S_CH_END:    op = hps_pkg::OP_CH_END;
			hps_pkg::S_DIV_GO:    op = hps_pkg::OP_DIV_GO;
			hps_pkg::S_PICK:      op = hps_pkg::OP_PICK;
			default:              op = hps_pkg::OP_NONE;
		endcase
	end

endmodule

// ----- rtl/hamiltonian_path_sampling_step.sv -----
// Step engine for sampling Hamiltonian cycles by random dives.
// Command channel: an item is taken when start is high and busy is low; its
// single result is on result with done high for exactly one cycle.
// The receiver cannot stall; done is not repeated, result holds till overwritten.
// Configuration channel: cfg_valid/cfg_ready with cfg_index and cfg_data;
// cfg_ready is high whenever the block is idle. Writing vertex_count or
// start_vertex ends a dive; writing rng_seed reloads the generator.
// A start dive marks the start vertex visited and updates the visit counts of
// its neighbor entries. A step runs one scan over free degrees, then for each
// unvisited neighbor of the head a flood fill through the single adjacency
// read port, then a bit-serial remainder of the generator state for the pick
// and a visit count update per neighbor entry of the picked vertex. One item
// is in work at a time.
// After reset: graph empty, no dive, vertex_count 120, start_vertex 0 and
// the generator holds the reset seed.
module hamiltonian_path_sampling_step #(
	parameter int MAX_VERTICES = 128,
	parameter int MAX_DEGREE = 6
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  hps_pkg::item_t   request,
	output logic             done,
	output hps_pkg::result_t result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [1:0]       cfg_index,
	input  logic [63:0]      cfg_data
);

	hps_pkg::dp_op_t   op;
	hps_pkg::dp_stat_t stat;

	assign cfg_ready = ~busy;

	hps_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.op     (op),
		.busy   (busy),
		.done   (done)
	);

	hps_dp #(
		.MAX_VERTICES (MAX_VERTICES),
		.MAX_DEGREE   (MAX_DEGREE)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (op),
		.request   (request),
		.cfg_we    (cfg_valid & cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.stat      (stat),
		.result    (result)
	);

endmodule
